/* design/assert_macros.svh */
// Assertion macros shared by the window average RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define OWA_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OWA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/owa_pkg.sv */
// Shared constants, types and helper functions of the window average block.
package owa_pkg;

    localparam int DEPTH       = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int SAMPLE_W    = 24;
    localparam int SUM_W       = SAMPLE_W + IDX_W;
    localparam int LEN_W       = 7;
    localparam int DIV_CNT_W   = $clog2(SUM_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int RES_BITS    = 4 * SAMPLE_W + LEN_W + 3;
    localparam int OUT_W       = ((RES_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_W - RES_BITS;
    localparam int APB_AW      = 3;

    localparam logic [LEN_W-1:0] LEN_RESET         = LEN_W'(64);
    localparam logic             REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t                        op;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed
    {
        logic             clear;
        logic [CNT_W-1:0] new_len;
    } cfg_ctl_t;

    // Last field in the lowest bits.
    typedef struct packed
    {
        logic [OUT_PAD_W-1:0]       pad;
        logic                       is_empty;
        logic                       is_full;
        logic [LEN_W-1:0]           sample_count;
        logic signed [SAMPLE_W-1:0] window_mean;
        logic signed [SAMPLE_W-1:0] newest_value;
        logic signed [SAMPLE_W-1:0] oldest_value;
        logic                       popped_valid;
        logic signed [SAMPLE_W-1:0] popped_value;
    } result_t;

    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] wl);
        logic [CNT_W-1:0] n;
        if (wl == '0)
        begin
            n = CNT_W'(1);
        end
        else if (int'(wl) > DEPTH)
        begin
            n = CNT_W'(DEPTH);
        end
        else
        begin
            n = CNT_W'(wl);
        end
        return n;
    endfunction

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] len);
        logic [CNT_W-1:0] nxt;
        nxt = CNT_W'(idx) + CNT_W'(1);
        return (nxt == len) ? '0 : nxt[IDX_W-1:0];
    endfunction

    localparam logic [IDX_W-1:0] TAIL_RESET = IDX_W'(eff_len(LEN_RESET) - CNT_W'(1));

endpackage

/* design/owa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module owa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/owa_front.sv */
// Input side: accepts beats, decodes the action and queues items for the sequencer.
module owa_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [owa_pkg::SAMPLE_W-1:0]  s_tdata,   // [23:0] sample
    input  logic                          s_tuser,   // [0] action
    output logic                          q_valid,
    output owa_pkg::item_t                q_item,
    input  logic                          q_pop
);

    owa_pkg::item_t                 entry_reg [owa_pkg::QUEUE_DEPTH];
    logic [owa_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [owa_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [owa_pkg::QPTR_W:0]       fill_reg, fill_next;
    logic                           push;
    logic                           pop;
    owa_pkg::item_t                 incoming;

    assign s_tready = (fill_reg != (owa_pkg::QPTR_W + 1)'(owa_pkg::QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb
    begin
        incoming.op     = s_tuser ? owa_pkg::OP_POP : owa_pkg::OP_PUSH;
        incoming.sample = s_tdata;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + owa_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + owa_pkg::QPTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + (owa_pkg::QPTR_W + 1)'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - (owa_pkg::QPTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

/* design/owa_div.sv */
// Restoring divider, one quotient bit per cycle, signed sum by unsigned count.
module owa_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [owa_pkg::SUM_W-1:0]    dividend,
    input  logic [owa_pkg::CNT_W-1:0]           divisor,
    output logic                                busy,
    output logic signed [owa_pkg::SAMPLE_W-1:0] quotient
);

    logic                               busy_reg, busy_next;
    logic [owa_pkg::DIV_CNT_W-1:0]      step_reg, step_next;
    logic                               neg_reg, neg_next;
    logic [owa_pkg::SUM_W-1:0]          quo_reg, quo_next;
    logic [owa_pkg::CNT_W-1:0]          rem_reg, rem_next;
    logic [owa_pkg::CNT_W-1:0]          divisor_reg, divisor_next;
    logic [owa_pkg::CNT_W:0]            shifted;
    logic [owa_pkg::CNT_W:0]            diff;
    logic [owa_pkg::SUM_W-1:0]          mag_out;

    assign shifted = {rem_reg, quo_reg[owa_pkg::SUM_W-1]};
    assign diff    = shifted - {1'b0, divisor_reg};
    assign mag_out = neg_reg ? (~quo_reg + owa_pkg::SUM_W'(1)) : quo_reg;
    assign quotient = mag_out[owa_pkg::SAMPLE_W-1:0];
    assign busy     = busy_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        step_next    = step_reg;
        neg_next     = neg_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            step_next    = owa_pkg::DIV_CNT_W'(owa_pkg::SUM_W - 1);
            neg_next     = dividend[owa_pkg::SUM_W-1];
            quo_next     = dividend[owa_pkg::SUM_W-1] ? (~dividend + owa_pkg::SUM_W'(1))
                                                      : dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[owa_pkg::CNT_W])
            begin
                rem_next = diff[owa_pkg::CNT_W-1:0];
                quo_next = {quo_reg[owa_pkg::SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[owa_pkg::CNT_W-1:0];
                quo_next = {quo_reg[owa_pkg::SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - owa_pkg::DIV_CNT_W'(1);
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg     <= neg_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

endmodule

/* design/owa_back.sv */
// Sequencer: updates the ring buffer, running sum and mean, and holds the result beat.
`include "assert_macros.svh"

module owa_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [owa_pkg::CNT_W-1:0]    len,
    input  owa_pkg::cfg_ctl_t            cfg,
    input  logic                         q_valid,
    input  owa_pkg::item_t               q_item,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [owa_pkg::OUT_W-1:0]    m_tdata
);

    typedef enum logic [7:0]
    {
        S_IDLE   = 8'b0000_0001,
        S_RM_RD  = 8'b0000_0010,
        S_RM     = 8'b0000_0100,
        S_WR     = 8'b0000_1000,
        S_OLD_RD = 8'b0001_0000,
        S_OLD    = 8'b0010_0000,
        S_DIV    = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } state_t;

    state_t                                state_reg, state_next;
    logic [owa_pkg::IDX_W-1:0]             head_reg, head_next;
    logic [owa_pkg::IDX_W-1:0]             tail_reg, tail_next;
    logic [owa_pkg::CNT_W-1:0]             count_reg, count_next;
    logic signed [owa_pkg::SUM_W-1:0]      sum_reg, sum_next;
    owa_pkg::item_t                        item_reg, item_next;
    logic signed [owa_pkg::SAMPLE_W-1:0]   popped_reg, popped_next;
    logic                                  popped_valid_reg, popped_valid_next;
    logic signed [owa_pkg::SAMPLE_W-1:0]   newest_reg, newest_next;
    logic signed [owa_pkg::SAMPLE_W-1:0]   oldest_reg, oldest_next;
    logic                                  out_valid_reg, out_valid_next;
    owa_pkg::result_t                      out_data_reg, out_data_next;

    logic                                  ram_we;
    logic [owa_pkg::IDX_W-1:0]             ram_waddr;
    logic                                  ram_re;
    logic [owa_pkg::SAMPLE_W-1:0]          ram_rdata;
    logic                                  div_start;
    logic                                  div_busy;
    logic signed [owa_pkg::SAMPLE_W-1:0]   div_q;
    logic signed [owa_pkg::SUM_W-1:0]      rd_ext;
    logic signed [owa_pkg::SUM_W-1:0]      wr_ext;
    logic                                  slot_free;
    logic                                  nonempty;

    owa_ram #(
        .WIDTH (owa_pkg::SAMPLE_W),
        .DEPTH (owa_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (item_reg.sample),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    owa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign rd_ext    = {{owa_pkg::IDX_W{ram_rdata[owa_pkg::SAMPLE_W-1]}}, ram_rdata};
    assign wr_ext    = {{owa_pkg::IDX_W{item_reg.sample[owa_pkg::SAMPLE_W-1]}},
                        item_reg.sample};
    assign ram_waddr = owa_pkg::wrap_inc(tail_reg, len);
    assign slot_free = !out_valid_reg || m_tready;
    assign nonempty  = (count_reg != '0);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        item_next         = item_reg;
        popped_next       = popped_reg;
        popped_valid_next = popped_valid_reg;
        newest_next       = newest_reg;
        oldest_next       = oldest_reg;
        out_valid_next    = m_tready ? 1'b0 : out_valid_reg;
        out_data_next     = out_data_reg;
        q_pop             = 1'b0;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        div_start         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop             = 1'b1;
                    item_next         = q_item;
                    popped_next       = '0;
                    popped_valid_next = 1'b0;
                    if (q_item.op == owa_pkg::OP_PUSH)
                    begin
                        state_next = (count_reg >= len) ? S_RM_RD : S_WR;
                    end
                    else
                    begin
                        state_next = nonempty ? S_RM_RD : S_FIN;
                    end
                end
            end
            S_RM_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_RM;
            end
            S_RM:
            begin
                sum_next   = sum_reg - rd_ext;
                head_next  = owa_pkg::wrap_inc(head_reg, len);
                count_next = count_reg - owa_pkg::CNT_W'(1);
                if (item_reg.op == owa_pkg::OP_POP)
                begin
                    popped_next       = ram_rdata;
                    popped_valid_next = 1'b1;
                    state_next        = (count_reg != owa_pkg::CNT_W'(1)) ? S_OLD_RD : S_FIN;
                end
                else
                begin
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                ram_we      = 1'b1;
                tail_next   = ram_waddr;
                count_next  = count_reg + owa_pkg::CNT_W'(1);
                sum_next    = sum_reg + wr_ext;
                newest_next = item_reg.sample;
                state_next  = S_OLD_RD;
            end
            S_OLD_RD:
            begin
                ram_re     = 1'b1;
                div_start  = 1'b1;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                oldest_next = ram_rdata;
                state_next  = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.pad          = '0;
                    out_data_next.is_empty     = !nonempty;
                    out_data_next.is_full      = (count_reg == len);
                    out_data_next.sample_count = owa_pkg::LEN_W'(count_reg);
                    out_data_next.window_mean  = nonempty ? div_q : '0;
                    out_data_next.newest_value = nonempty ? newest_reg : '0;
                    out_data_next.oldest_value = nonempty ? oldest_reg : '0;
                    out_data_next.popped_valid = popped_valid_reg;
                    out_data_next.popped_value = popped_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.clear)
        begin
            head_next  = '0;
            tail_next  = owa_pkg::IDX_W'(cfg.new_len - owa_pkg::CNT_W'(1));
            count_next = '0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg         <= item_next;
        popped_reg       <= popped_next;
        popped_valid_reg <= popped_valid_next;
        newest_reg       <= newest_next;
        oldest_reg       <= oldest_next;
        out_data_reg     <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= owa_pkg::TAIL_RESET;
            count_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `OWA_ASSERT(a_count_in_window, 1'b1, count_reg <= len, "count exceeds window")
    `OWA_ASSERT(a_index_in_window, 1'b1,
                ({1'b0, head_reg} < len) && ({1'b0, tail_reg} < len),
                "ring index outside window")
    `OWA_ASSERT(a_div_idle, state_reg == S_IDLE, !div_busy, "divider busy while idle")
    `OWA_ASSERT_NEXT(a_push_nonempty, state_reg == S_WR, count_reg != '0,
                     "buffer empty after push")

endmodule

/* design/overwriting_window_average_core.sv */
// Top level of the overwriting window average block: register port, front and back.
//
// Input beats (s_*): s_tuser is the action (0 push, 1 pop), s_tdata the signed
// Q16.8 sample. Each accepted beat yields exactly one result beat on m_*, in order.
// m_tdata carries popped value, popped flag, oldest, newest, mean, count, full, empty.
// A two-entry queue sits between the input side and the sequencer, and the result
// sits in its own output register, so input stays open while a result waits.
// Steps: a push runs S_WR, S_OLD_RD, S_OLD, S_DIV and S_FIN, with S_RM_RD and S_RM
// first when it evicts the oldest sample; a pop that leaves samples behind runs
// S_RM_RD and S_RM, then the same ring RAM read, divide and finish states, the mean
// coming from the 30-step serial divider. A pop that empties the buffer goes from
// S_RM to S_FIN, and a pop of an empty buffer goes straight to S_FIN. The sequencer
// takes one item at a time; the queue keeps accepting beats meanwhile until full.
// When the receiver stalls, the finished beat holds; the sequencer parks in its
// final step and the queue fills, after which s_tready drops.
// Reset empties the buffer and the queue; window_length returns to 64.
// Writing window_length (APB offset 0) clears the buffer; write only when idle.
module overwriting_window_average_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [owa_pkg::SAMPLE_W-1:0]  s_tdata,   // [23:0] sample
    input  logic                          s_tuser,   // [0] action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [23:0] popped_value, [24] popped_valid, [48:25] oldest_value,
    // [72:49] newest_value, [96:73] window_mean, [103:97] sample_count,
    // [104] is_full, [105] is_empty, [111:106] zero
    output logic [owa_pkg::OUT_W-1:0]     m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [owa_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [owa_pkg::LEN_W-1:0]  window_length_reg, window_length_next;
    logic                       reg_write;
    logic [owa_pkg::CNT_W-1:0]  len;
    owa_pkg::cfg_ctl_t          cfg;
    logic                       q_valid;
    owa_pkg::item_t             q_item;
    logic                       q_pop;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready
                       && (paddr[2] == owa_pkg::REG_WINDOW_LENGTH);
    assign len       = owa_pkg::eff_len(window_length_reg);
    assign prdata    = (paddr[2] == owa_pkg::REG_WINDOW_LENGTH)
                       ? {{(32 - owa_pkg::LEN_W){1'b0}}, window_length_reg} : '0;

    always_comb
    begin
        window_length_next = reg_write ? pwdata[owa_pkg::LEN_W-1:0] : window_length_reg;
        cfg.clear          = reg_write;
        cfg.new_len        = owa_pkg::eff_len(pwdata[owa_pkg::LEN_W-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= owa_pkg::LEN_RESET;
        end
        else
        begin
            window_length_reg <= window_length_next;
        end
    end

    owa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    owa_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .len      (len),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* sim/window_average_checker.sv */
// Checker for the window average core: tracks the ring buffer and compares result beats.
module window_average_checker
    import owa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OUT_W-1:0]    m_tdata,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [31:0]         pwdata,
    input  logic [31:0]         prdata,
    input  logic                pready,
    output int                  mismatches,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [LEN_W-1:0]           window_len_reg;
    logic signed [SAMPLE_W-1:0] ring [DEPTH];
    logic [IDX_W-1:0]           oldest_idx;
    logic [IDX_W-1:0]           newest_idx;
    logic [CNT_W-1:0]           fill;
    logic signed [SUM_W-1:0]    window_sum;
    result_t                    expected_results [$];
    int                         fail_count = 0;
    int                         waiting = 0;

    assign mismatches  = fail_count;
    assign outstanding = waiting;

    initial
    begin
        foreach (ring[i])
        begin
            ring[i] = '0;
        end
    end

    function automatic logic [CNT_W-1:0] active_span();
        if (window_len_reg == '0)
        begin
            return CNT_W'(1);
        end
        if (int'(window_len_reg) > DEPTH)
        begin
            return CNT_W'(DEPTH);
        end
        return CNT_W'(window_len_reg);
    endfunction

    function automatic void empty_window();
        oldest_idx = '0;
        fill       = '0;
        newest_idx = IDX_W'(active_span() - CNT_W'(1));
        window_sum = '0;
    endfunction

    function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx);
        return IDX_W'((int'(idx) + 1) % int'(active_span()));
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] drop_oldest();
        logic signed [SAMPLE_W-1:0] v;
        v          = ring[oldest_idx];
        oldest_idx = step_idx(oldest_idx);
        fill       = fill - CNT_W'(1);
        window_sum = window_sum - SUM_W'(v);
        return v;
    endfunction

    function automatic result_t predict_window_step(input op_t op,
                                                    input logic signed [SAMPLE_W-1:0] smp);
        result_t          r;
        logic [CNT_W-1:0] span;
        r    = '0;
        span = active_span();
        if (op == OP_PUSH)
        begin
            // full window: oldest goes quietly, nothing reported as popped
            if (fill >= span)
            begin
                void'(drop_oldest());
            end
            newest_idx       = step_idx(newest_idx);
            ring[newest_idx] = smp;
            fill             = fill + CNT_W'(1);
            window_sum       = window_sum + SUM_W'(smp);
        end
        else if (fill != '0)
        begin
            r.popped_value = drop_oldest();
            r.popped_valid = 1'b1;
        end
        if (fill != '0)
        begin
            r.oldest_value = ring[oldest_idx];
            r.newest_value = ring[newest_idx];
            r.window_mean  = SAMPLE_W'(longint'(window_sum) / longint'(fill));
        end
        r.sample_count = LEN_W'(fill);
        r.is_full      = (fill == span);
        r.is_empty     = (fill == '0);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        fail_count++;
        $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            window_len_reg = LEN_RESET;
            empty_window();
            expected_results.delete();
            waiting = 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite && (paddr >> 2) == APB_AW'(REG_WINDOW_LENGTH))
                begin
                    window_len_reg = pwdata[LEN_W-1:0];
                    empty_window();
                end
                else if (!pwrite && prdata !== 32'(window_len_reg))
                begin
                    flag_mismatch("window_length readback", prdata, 32'(window_len_reg));
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(predict_window_step(op_t'(s_tuser), s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_results.size() == 0)
                begin
                    flag_mismatch("result beat with nothing outstanding", m_tdata[31:0], '0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.pad !== want.pad)
                        flag_mismatch("pad", 32'(got.pad), 32'(want.pad));
                    if (got.popped_value !== want.popped_value)
                        flag_mismatch("popped_value", got.popped_value, want.popped_value);
                    if (got.popped_valid !== want.popped_valid)
                        flag_mismatch("popped_valid", got.popped_valid, want.popped_valid);
                    if (got.oldest_value !== want.oldest_value)
                        flag_mismatch("oldest_value", got.oldest_value, want.oldest_value);
                    if (got.newest_value !== want.newest_value)
                        flag_mismatch("newest_value", got.newest_value, want.newest_value);
                    if (got.window_mean !== want.window_mean)
                        flag_mismatch("window_mean", got.window_mean, want.window_mean);
                    if (got.sample_count !== want.sample_count)
                        flag_mismatch("sample_count", got.sample_count, want.sample_count);
                    if (got.is_full !== want.is_full)
                        flag_mismatch("is_full", got.is_full, want.is_full);
                    if (got.is_empty !== want.is_empty)
                        flag_mismatch("is_empty", got.is_empty, want.is_empty);
                end
            end
            waiting = expected_results.size();
        end
    end

endmodule

/* sim/overwriting_window_average_core_tb.sv */
// Testbench top for the window average core: clock, reset, stimulus and verdict.
module overwriting_window_average_core_tb;
    import owa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int SETTLE       = 48;

    localparam logic [APB_AW-1:0] WINDOW_LENGTH_ADDR = APB_AW'(4 * int'(REG_WINDOW_LENGTH));

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [SAMPLE_W-1:0] s_tdata;   // [23:0] sample
    logic                s_tuser;   // [0] action
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;   // popped, flag, oldest, newest, mean, count, full, empty
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int                  pending;
    int                  failures;
    int                  cycles;
    bit                  calm;

    overwriting_window_average_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    window_average_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .mismatches  (failures),
        .outstanding (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[overwriting_window_average_core] ERROR");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
            3:       return $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    initial
    begin
        int busy;
        m_tready = 1'b0;
        forever
        begin
            busy = calm ? 0 : pick_gap();
            if (busy > 0)
            begin
                @(negedge clk);
                m_tready = 1'b0;
                repeat (busy - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready = 1'b1;
            repeat ($urandom_range(0, 8)) @(negedge clk);
        end
    end

    task automatic send_beat(input op_t op, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            s_tdata  = SAMPLE_W'($urandom);
            s_tuser  = 1'($urandom);
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = smp;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain(input int extra);
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending == 0);
        repeat (extra) @(negedge clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = WINDOW_LENGTH_ADDR;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure_window(input logic [LEN_W-1:0] wl);
        drain(SETTLE);
        apb_cycle(1'b1, {(32 - LEN_W)'($urandom), wl});
        apb_cycle(1'b0, '0);
    endtask

    initial
    begin
        int               random_sent;
        int               plan_idx;
        int               phase_items;
        int               burst;
        int               mode;
        logic [LEN_W-1:0] wl;
        logic [SAMPLE_W-1:0] extreme;
        logic [SAMPLE_W-1:0] smp;
        op_t              op;

        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        calm     = 1'b0;
        rst_n    = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // reset value readback, then the default window of 64
        apb_cycle(1'b0, '0);
        send_beat(OP_POP,  24'h000000);
        send_beat(OP_PUSH, 24'h7FFFFF);
        send_beat(OP_PUSH, 24'h800000);
        send_beat(OP_PUSH, 24'hFFFFFF);
        send_beat(OP_PUSH, 24'h000000);
        send_beat(OP_PUSH, 24'h000001);
        send_beat(OP_PUSH, 24'h000100);
        send_beat(OP_PUSH, 24'h7FFFFF);
        repeat (8) send_beat(OP_POP, pick_sample());

        // short window: overwrite when full, then pop down past empty
        configure_window(LEN_W'(3));
        send_beat(OP_PUSH, 24'h000A00);
        send_beat(OP_PUSH, 24'hFFF600);
        send_beat(OP_PUSH, 24'h7FFFFF);
        send_beat(OP_PUSH, 24'h800000);
        send_beat(OP_PUSH, 24'h123456);
        repeat (4) send_beat(OP_POP, pick_sample());

        random_sent = 0;
        plan_idx    = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            case (plan_idx)
                0:       wl = LEN_W'(1);
                1:       wl = LEN_W'(0);
                2:       wl = LEN_W'(127);
                3:       wl = LEN_W'(2);
                4:       wl = LEN_W'(64);
                5:       wl = LEN_W'(65);
                6:       wl = LEN_W'(7);
                7:       wl = LEN_W'(100);
                8:       wl = LEN_W'(16);
                9:       wl = LEN_W'(33);
                default: wl = LEN_W'($urandom_range(0, 127));
            endcase
            plan_idx++;
            configure_window(wl);
            calm        = ($urandom_range(0, 3) == 0);
            phase_items = $urandom_range(60, 160);
            while (phase_items > 0 && random_sent < RANDOM_ITEMS)
            begin
                mode    = $urandom_range(0, 3);
                burst   = $urandom_range(1, 140);
                extreme = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
                while (burst > 0 && phase_items > 0)
                begin
                    smp = pick_sample();
                    case (mode)
                        0:       op = ($urandom_range(0, 99) < 85) ? OP_PUSH : OP_POP;
                        1:       op = ($urandom_range(0, 99) < 20) ? OP_PUSH : OP_POP;
                        2:       op = ($urandom_range(0, 99) < 50) ? OP_PUSH : OP_POP;
                        default:
                        begin
                            // same extreme over and over: drives the sum to its limits
                            op  = OP_PUSH;
                            smp = extreme;
                        end
                    endcase
                    send_beat(op, smp);
                    if ($urandom_range(0, 49) == 0)
                    begin
                        drain(0);
                    end
                    burst--;
                    phase_items--;
                    random_sent++;
                end
            end
        end

        drain(SETTLE);
        if (failures == 0)
        begin
            $display("[overwriting_window_average_core] OK");
        end
        else
        begin
            $display("[overwriting_window_average_core] ERROR");
        end
        $finish;
    end

endmodule

/* overwriting_window_average_core.f */
+incdir+design
design/owa_pkg.sv
design/owa_ram.sv
design/owa_front.sv
design/owa_div.sv
design/owa_back.sv
design/overwriting_window_average_core.sv
sim/window_average_checker.sv
sim/overwriting_window_average_core_tb.sv
